### src/arp_pkg.sv
// ---------------------------------------------------------------------------
// Arpeggiator package
// Shared constants, codes and the command and status groups that join the
// controller and the datapath.
// ---------------------------------------------------------------------------
package arp_pkg;

  // Default sizes for the top-level parameters.
  localparam int HELD_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;

  // Stream and configuration widths.
  localparam int IN_W   = 80;
  localparam int OUT_W  = 112;
  localparam int USER_W = 2;
  localparam int CIDX_W = 3;

  // Request codes (s_tuser).
  localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
  localparam logic [1:0] REQ_NOTE_OFF = 2'd1;
  localparam logic [1:0] REQ_TICK     = 2'd2;

  // Result kinds (m_tuser).
  localparam logic [1:0] KIND_IDLE    = 2'd0;
  localparam logic [1:0] KIND_STEP    = 2'd1;
  localparam logic [1:0] KIND_FWD_ON  = 2'd2;
  localparam logic [1:0] KIND_FWD_OFF = 2'd3;

  // Pattern modes.
  localparam logic [1:0] MODE_UP     = 2'd0;
  localparam logic [1:0] MODE_DOWN   = 2'd1;
  localparam logic [1:0] MODE_UPDOWN = 2'd2;
  localparam logic [1:0] MODE_RANDOM = 2'd3;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_SPAN   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_PERIOD = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_GATE   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_FIXVEL = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_PASS   = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_SEED   = 3'd6;

  // Configuration reset values.
  localparam logic [1:0]  MODE_RST   = 2'd0;
  localparam logic [1:0]  SPAN_RST   = 2'd1;
  localparam logic [13:0] PERIOD_RST = 14'd200;
  localparam logic [13:0] GATE_RST   = 14'd150;
  localparam logic [31:0] SEED_RST   = 32'd5489;

  // Note arithmetic.
  localparam logic [6:0] OCTAVE   = 7'd12;
  localparam logic [6:0] OCT1_MAX = 7'd115;
  localparam logic [6:0] OCT2_MAX = 7'd103;

  // Mersenne twister constants.
  localparam int          MT_N      = 624;
  localparam int          MT_M      = 397;
  localparam int          MT_AW     = 10;
  localparam logic [31:0] MT_MULT   = 32'd1812433253;
  localparam logic [31:0] MT_MATRIX = 32'h9908b0df;
  localparam logic [31:0] MT_TMASKB = 32'h9d2c5680;
  localparam logic [31:0] MT_TMASKC = 32'hefc60000;

  // Result selection for the output register.
  typedef enum logic [2:0] {
    RES_FWD_ON  = 3'd0,
    RES_FWD_OFF = 3'd1,
    RES_FULL    = 3'd2,
    RES_TICK    = 3'd3,
    RES_STEP    = 3'd4
  } res_sel_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic     latch_in;
    logic     rm_match;
    logic     append;
    logic     scan_init;
    logic     scan_step;
    logic     rank;
    logic     len;
    logic     mt_draw;
    logic     div_start;
    logic     pick;
    logic     select;
    logic     load_res;
    res_sel_t res_sel;
  } arp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] req;
    logic       full;
    logic       count_zero;
    logic       scan_zero;
    logic       running;
    logic       pass;
    logic       random;
    logic       mt_idle;
    logic       mt_valid;
    logic       div_done;
    logic       out_free;
  } arp_stat_t;

endpackage

### src/arp_mt.sv
// ---------------------------------------------------------------------------
// Arpeggiator random generator
// MT19937 with its 624-word state in a memory; seeding, twisting and drawing
// are sequenced one word at a time.
// ---------------------------------------------------------------------------
module arp_mt (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_load,
  input  logic [31:0] seed,
  input  logic        draw,
  output logic        idle,
  output logic        value_valid,
  output logic [31:0] value
);
  import arp_pkg::*;

  typedef enum logic [8:0] {
    M_IDLE  = 9'b000000001,
    M_SEED0 = 9'b000000010,
    M_SEED  = 9'b000000100,
    M_TW0   = 9'b000001000,
    M_TW1   = 9'b000010000,
    M_TWRD  = 9'b000100000,
    M_TWWR  = 9'b001000000,
    M_RD    = 9'b010000000,
    M_OUT   = 9'b100000000
  } mt_state_t;

  localparam logic [MT_AW-1:0] LAST = MT_AW'(MT_N - 1);
  localparam logic [MT_AW-1:0] SPLIT = MT_AW'(MT_N - MT_M);

  mt_state_t        state;
  mt_state_t        state_next;
  logic [MT_AW-1:0] cnt;
  logic [MT_AW-1:0] mt_index;
  logic [31:0]      prev;
  logic [31:0]      mem [MT_N];
  logic [31:0]      rda;
  logic [31:0]      rdb;
  logic [MT_AW-1:0] ra;
  logic [MT_AW-1:0] rb;
  logic             we;
  logic [MT_AW-1:0] waddr;
  logic [31:0]      wdata;
  logic [31:0]      seed_word;
  logic [31:0]      twist_x;
  logic [31:0]      twist_word;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & MT_TMASKB);
    y = y ^ ((y << 15) & MT_TMASKC);
    y = y ^ (y >> 18);
    return y;
  endfunction

  assign idle = (state == M_IDLE);

  // Next seed word from the previous one.
  assign seed_word = MT_MULT * (prev ^ (prev >> 30)) + 32'(cnt);

  // Twist of word cnt; prev holds the old word cnt.
  assign twist_x    = {prev[31], rda[30:0]};
  assign twist_word = rdb ^ (twist_x >> 1) ^ (twist_x[0] ? MT_MATRIX : 32'd0);

  always_comb begin
    state_next = state;
    we    = 1'b0;
    waddr = cnt;
    wdata = seed_word;
    ra    = mt_index;
    rb    = '0;
    unique case (state)
      M_IDLE: begin
        if (draw) begin
          state_next = (mt_index == MT_AW'(MT_N)) ? M_TW0 : M_RD;
        end
      end
      M_SEED0: begin
        we    = 1'b1;
        waddr = '0;
        wdata = seed;
        state_next = M_SEED;
      end
      M_SEED: begin
        we = 1'b1;
        if (cnt == LAST) begin
          state_next = M_IDLE;
        end
      end
      M_TW0: begin
        ra = '0;
        state_next = M_TW1;
      end
      M_TW1: begin
        state_next = M_TWRD;
      end
      M_TWRD: begin
        ra = (cnt == LAST) ? '0 : cnt + 1'b1;
        rb = (cnt < SPLIT) ? cnt + MT_AW'(MT_M) : cnt - SPLIT;
        state_next = M_TWWR;
      end
      M_TWWR: begin
        we    = 1'b1;
        wdata = twist_word;
        state_next = (cnt == LAST) ? M_RD : M_TWRD;
      end
      M_RD: begin
        state_next = M_OUT;
      end
      M_OUT: begin
        state_next = M_IDLE;
      end
      default: state_next = M_IDLE;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= M_SEED0;
      mt_index    <= MT_AW'(MT_N);
      cnt         <= '0;
      value_valid <= 1'b0;
    end else if (seed_load) begin
      state       <= M_SEED0;
      value_valid <= 1'b0;
    end else begin
      state       <= state_next;
      value_valid <= 1'b0;
      unique case (state)
        M_SEED0: cnt <= MT_AW'(1);
        M_SEED: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST) begin
            mt_index <= MT_AW'(MT_N);
          end
        end
        M_TW0: cnt <= '0;
        M_TWWR: begin
          if (cnt == LAST) begin
            mt_index <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        M_OUT: begin
          value_valid <= 1'b1;
          mt_index    <= mt_index + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Previous or current word and the drawn value.
  always_ff @(posedge clk) begin
    unique case (state)
      M_SEED0: prev <= seed;
      M_SEED:  prev <= seed_word;
      M_TW1:   prev <= rda;
      M_TWWR:  prev <= rda;
      default: ;
    endcase
    if (state == M_OUT) begin
      value <= temper(rda);
    end
  end

  // State memory: one write and two registered reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rda <= mem[ra];
    rdb <= mem[rb];
  end

endmodule

### src/arp_div.sv
// ---------------------------------------------------------------------------
// Arpeggiator remainder unit
// Restoring division, one dividend bit per cycle, returning the remainder.
// ---------------------------------------------------------------------------
module arp_div #(
  parameter int DW = 32,
  parameter int VW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [VW-1:0] rem
);
  localparam int CNT_W = $clog2(DW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    shreg;
  logic [VW:0]      trial;

  assign trial = {rem, shreg[DW-1]};

  // Busy flag and done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // One restoring step per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      cnt   <= CNT_W'(DW);
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      cnt   <= cnt - 1'b1;
      shreg <= shreg << 1;
      if (trial >= {1'b0, divisor}) begin
        rem <= VW'(trial - {1'b0, divisor});
      end else begin
        rem <= VW'(trial);
      end
    end
  end

endmodule

### src/arp_dp.sv
// ---------------------------------------------------------------------------
// Arpeggiator datapath
// Configuration registers, held-note store, step selection arithmetic and
// the output register.
// ---------------------------------------------------------------------------
module arp_dp #(
  parameter int DEPTH = arp_pkg::HELD_DEPTH_DEF,
  parameter int TB    = arp_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  arp_pkg::arp_cmd_t           cmd,
  output arp_pkg::arp_stat_t          stat,
  input  logic [arp_pkg::IN_W-1:0]    s_tdata,
  input  logic [arp_pkg::USER_W-1:0]  s_tuser,
  input  logic                        cfg_valid,
  input  logic [arp_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [31:0]                 cfg_data,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [arp_pkg::OUT_W-1:0]   m_tdata,
  output logic [arp_pkg::USER_W-1:0]  m_tuser
);
  import arp_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = $clog2(3 * DEPTH + 1);
  localparam int YW = $clog2(6 * DEPTH);

  // Configuration.
  logic [1:0]  mode;
  logic [1:0]  span;
  logic [13:0] period;
  logic [13:0] gate;
  logic [6:0]  fixvel;
  logic        pass;
  logic [31:0] seed;
  logic        seed_load;

  // Latched request.
  logic [1:0]  in_req;
  logic [6:0]  in_note;
  logic [6:0]  in_vel;
  logic [31:0] in_dur;
  logic [31:0] in_time;
  logic        in_run;
  logic [TB-1:0] now;
  logic [31:0] next_tick;

  // Held store.
  logic [6:0]    pitch   [DEPTH];
  logic [6:0]    level   [DEPTH];
  logic [TB-1:0] release_t [DEPTH];
  logic          timed   [DEPTH];
  logic [CW-1:0] count;
  logic          match;
  logic [IW-1:0] match_idx;
  logic [IW-1:0] scan_idx;
  logic          due;
  logic          rm_en;
  logic [IW-1:0] rm_idx;

  // Step selection.
  logic [IW-1:0] rank_c [DEPTH];
  logic [IW-1:0] rank_r [DEPTH];
  logic [CW-1:0] c1_c;
  logic [CW-1:0] c2_c;
  logic [CW-1:0] c1_r;
  logic [CW-1:0] c2_r;
  logic [LW-1:0] len_c;
  logic [LW-1:0] len_r;
  logic [YW-1:0] cyc_c;
  logic [YW-1:0] divisor;
  logic [YW-1:0] rem;
  logic          div_done;
  logic [YW-1:0] pick_w;
  logic [LW-1:0] pick_r;
  logic [1:0]    oct;
  logic [IW-1:0] rsel;
  logic [6:0]    sel_pitch;
  logic [6:0]    sel_level;
  logic [6:0]    oct_add;
  logic [6:0]    step_note;
  logic [6:0]    step_vel;
  logic [31:0]   step_pos;

  // Random generator.
  logic        mt_idle;
  logic        mt_valid;
  logic [31:0] mt_value;

  // Output register.
  logic [1:0]  o_kind;
  logic [6:0]  o_note;
  logic [6:0]  o_vel;
  logic [31:0] o_dur;
  logic [31:0] o_time;
  logic [31:0] o_next;
  logic        o_full;

  // Configuration writes; a seed write restarts the generator next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_RST;
      span      <= SPAN_RST;
      period    <= PERIOD_RST;
      gate      <= GATE_RST;
      fixvel    <= '0;
      pass      <= 1'b0;
      seed      <= SEED_RST;
      seed_load <= 1'b0;
    end else begin
      seed_load <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MODE:   mode   <= cfg_data[1:0];
          CFG_SPAN:   span   <= cfg_data[1:0];
          CFG_PERIOD: period <= cfg_data[13:0];
          CFG_GATE:   gate   <= cfg_data[13:0];
          CFG_FIXVEL: fixvel <= cfg_data[6:0];
          CFG_PASS:   pass   <= cfg_data[0];
          CFG_SEED: begin
            seed      <= cfg_data;
            seed_load <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_req  <= s_tuser;
      in_note <= s_tdata[6:0];
      in_vel  <= s_tdata[13:7];
      in_dur  <= s_tdata[45:14];
      in_time <= s_tdata[77:46];
      in_run  <= s_tdata[78];
    end
  end

  assign now       = TB'(in_time);
  assign next_tick = 32'(now + TB'(period));

  // First held entry with the request's note.
  always_comb begin
    match     = 1'b0;
    match_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (CW'(i) < count && pitch[i] == in_note) begin
        match     = 1'b1;
        match_idx = IW'(i);
      end
    end
  end

  assign due    = timed[scan_idx] && (release_t[scan_idx] <= now);
  assign rm_en  = (cmd.rm_match && match) || (cmd.scan_step && due);
  assign rm_idx = cmd.rm_match ? match_idx : scan_idx;

  // Held count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (rm_en) begin
      count <= count - 1'b1;
    end else if (cmd.append) begin
      count <= count + 1'b1;
    end
  end

  // Entry removal closes the gap; a new note goes to the end.
  always_ff @(posedge clk) begin
    if (rm_en) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (IW'(i) >= rm_idx) begin
          pitch[i]     <= pitch[i+1];
          level[i]     <= level[i+1];
          release_t[i] <= release_t[i+1];
          timed[i]     <= timed[i+1];
        end
      end
    end else if (cmd.append) begin
      pitch[IW'(count)]     <= in_note;
      level[IW'(count)]     <= in_vel;
      timed[IW'(count)]     <= (in_dur != '0);
      release_t[IW'(count)] <= (in_dur != '0) ? now + TB'(in_dur) : '0;
    end
  end

  // Expiry scan runs from the last entry down.
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_idx <= IW'(count - 1'b1);
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx - 1'b1;
    end
  end

  // Sorted position of every entry and the counts kept per octave.
  always_comb begin
    logic [DEPTH-1:0] lt;
    logic [DEPTH-1:0] le1;
    logic [DEPTH-1:0] le2;
    for (int i = 0; i < DEPTH; i++) begin
      for (int j = 0; j < DEPTH; j++) begin
        lt[j] = (CW'(j) < count) && (pitch[j] < pitch[i]);
      end
      rank_c[i] = IW'($countones(lt));
      le1[i] = (CW'(i) < count) && (pitch[i] <= OCT1_MAX);
      le2[i] = (CW'(i) < count) && (pitch[i] <= OCT2_MAX);
    end
    c1_c = CW'($countones(le1));
    c2_c = CW'($countones(le2));
  end

  always_ff @(posedge clk) begin
    if (cmd.rank) begin
      rank_r <= rank_c;
      c1_r   <= c1_c;
      c2_r   <= c2_c;
    end
  end

  // Sequence length and the divisor for the step index.
  assign len_c = LW'(count) + ((span >= 2'd2) ? LW'(c1_r) : '0)
               + ((span == 2'd3) ? LW'(c2_r) : '0);
  assign cyc_c = (YW'(len_c) << 1) - YW'(2);

  always_ff @(posedge clk) begin
    if (cmd.len) begin
      len_r   <= len_c;
      divisor <= (mode == MODE_UPDOWN && len_c > LW'(1)) ? cyc_c : YW'(len_c);
    end
  end

  arp_mt u_mt (
    .clk         (clk),
    .rst         (rst),
    .seed_load   (seed_load),
    .seed        (seed),
    .draw        (cmd.mt_draw),
    .idle        (mt_idle),
    .value_valid (mt_valid),
    .value       (mt_value)
  );

  arp_div #(
    .DW (32),
    .VW (YW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ((mode == MODE_RANDOM) ? mt_value : step_pos),
    .divisor  (divisor),
    .done     (div_done),
    .rem      (rem)
  );

  // Pattern position from the remainder.
  always_comb begin
    case (mode)
      MODE_DOWN:   pick_w = YW'(len_r) - YW'(1) - rem;
      MODE_UPDOWN: begin
        if (len_r == LW'(1)) begin
          pick_w = '0;
        end else begin
          pick_w = (rem < YW'(len_r)) ? rem : divisor - rem;
        end
      end
      default:     pick_w = rem;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      pick_r <= LW'(pick_w);
    end
  end

  // Octave and rank of the chosen position, then the entry with that rank.
  always_comb begin
    if (pick_r < LW'(count)) begin
      oct  = 2'd0;
      rsel = IW'(pick_r);
    end else if (pick_r < LW'(count) + LW'(c1_r)) begin
      oct  = 2'd1;
      rsel = IW'(pick_r - LW'(count));
    end else begin
      oct  = 2'd2;
      rsel = IW'(pick_r - LW'(count) - LW'(c1_r));
    end
    sel_pitch = '0;
    sel_level = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CW'(i) < count && rank_r[i] == rsel) begin
        sel_pitch = pitch[i];
        sel_level = level[i];
      end
    end
    case (oct)
      2'd1:    oct_add = OCTAVE;
      2'd2:    oct_add = OCTAVE << 1;
      default: oct_add = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.select) begin
      step_note <= sel_pitch + oct_add;
      step_vel  <= (fixvel != '0) ? fixvel : sel_level;
    end
  end

  // Step counter advances with every step note sent.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_pos <= '0;
    end else if (cmd.load_res && cmd.res_sel == RES_STEP) begin
      step_pos <= step_pos + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_res) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      unique case (cmd.res_sel) inside
        RES_FWD_ON, RES_FWD_OFF: begin
          o_kind <= (cmd.res_sel == RES_FWD_ON) ? KIND_FWD_ON : KIND_FWD_OFF;
          o_note <= in_note;
          o_vel  <= in_vel;
          o_dur  <= in_dur;
          o_time <= in_time;
          o_next <= '0;
          o_full <= 1'b0;
        end
        RES_FULL: begin
          o_kind <= pass ? KIND_FWD_ON : KIND_IDLE;
          o_note <= pass ? in_note : '0;
          o_vel  <= pass ? in_vel : '0;
          o_dur  <= pass ? in_dur : '0;
          o_time <= pass ? in_time : '0;
          o_next <= '0;
          o_full <= 1'b1;
        end
        RES_STEP: begin
          o_kind <= KIND_STEP;
          o_note <= step_note;
          o_vel  <= step_vel;
          o_dur  <= 32'(gate);
          o_time <= 32'(now);
          o_next <= next_tick;
          o_full <= 1'b0;
        end
        default: begin
          o_kind <= KIND_IDLE;
          o_note <= '0;
          o_vel  <= '0;
          o_dur  <= '0;
          o_time <= 32'(now);
          o_next <= next_tick;
          o_full <= 1'b0;
        end
      endcase
    end
  end

  assign m_tdata = {1'b0, o_full, o_next, o_time, o_dur, o_vel, o_note};
  assign m_tuser = o_kind;

  // Status toward the controller.
  assign stat.req        = in_req;
  assign stat.full       = (count == CW'(DEPTH));
  assign stat.count_zero = (count == '0);
  assign stat.scan_zero  = (scan_idx == '0);
  assign stat.running    = in_run;
  assign stat.pass       = pass;
  assign stat.random     = (mode == MODE_RANDOM);
  assign stat.mt_idle    = mt_idle && !seed_load;
  assign stat.mt_valid   = mt_valid;
  assign stat.div_done   = div_done;
  assign stat.out_free   = !m_tvalid || m_tready;

endmodule

### src/arp_ctrl.sv
// ---------------------------------------------------------------------------
// Arpeggiator controller
// Sequences one request at a time through the datapath.
// ---------------------------------------------------------------------------
module arp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  arp_pkg::arp_stat_t  stat,
  output arp_pkg::arp_cmd_t   cmd
);
  import arp_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_DECODE = 16'h0002,
    S_FIND   = 16'h0004,
    S_NOTEON = 16'h0008,
    S_SCAN0  = 16'h0010,
    S_SCAN   = 16'h0020,
    S_AFTER  = 16'h0040,
    S_RANK   = 16'h0080,
    S_LEN    = 16'h0100,
    S_DRAW   = 16'h0200,
    S_DRAWW  = 16'h0400,
    S_DIV    = 16'h0800,
    S_DIVW   = 16'h1000,
    S_PICK   = 16'h2000,
    S_SEL    = 16'h4000,
    S_EMIT   = 16'h8000
  } ctrl_state_t;

  ctrl_state_t state;
  ctrl_state_t state_next;
  res_sel_t    res;
  res_sel_t    res_next;

  assign s_tready = (state == S_IDLE) && stat.mt_idle;

  always_comb begin
    state_next = state;
    res_next   = res;
    cmd        = '0;
    cmd.res_sel = res;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.req) inside
          REQ_NOTE_ON, REQ_NOTE_OFF: state_next = S_FIND;
          REQ_TICK:                  state_next = S_SCAN0;
          default:                   state_next = S_IDLE;
        endcase
      end
      S_FIND: begin
        cmd.rm_match = 1'b1;
        if (stat.req == REQ_NOTE_ON) begin
          state_next = S_NOTEON;
        end else if (stat.pass) begin
          res_next   = RES_FWD_OFF;
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_NOTEON: begin
        if (stat.full) begin
          res_next   = RES_FULL;
          state_next = S_EMIT;
        end else begin
          cmd.append = 1'b1;
          res_next   = RES_FWD_ON;
          state_next = stat.pass ? S_EMIT : S_IDLE;
        end
      end
      S_SCAN0: begin
        if (stat.count_zero) begin
          state_next = S_AFTER;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_zero) begin
          state_next = S_AFTER;
        end
      end
      S_AFTER: begin
        if (stat.running && !stat.count_zero) begin
          state_next = S_RANK;
        end else begin
          res_next   = RES_TICK;
          state_next = S_EMIT;
        end
      end
      S_RANK: begin
        cmd.rank   = 1'b1;
        state_next = S_LEN;
      end
      S_LEN: begin
        cmd.len    = 1'b1;
        state_next = stat.random ? S_DRAW : S_DIV;
      end
      S_DRAW: begin
        cmd.mt_draw = 1'b1;
        state_next  = S_DRAWW;
      end
      S_DRAWW: begin
        if (stat.mt_valid) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVW;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick   = 1'b1;
        state_next = S_SEL;
      end
      S_SEL: begin
        cmd.select = 1'b1;
        res_next   = RES_STEP;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_res = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res   <= RES_TICK;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

endmodule

### src/note_arpeggiator_core.sv
// ---------------------------------------------------------------------------
// Note arpeggiator core
// Holds played notes and answers each tick with one arpeggio step.
// ---------------------------------------------------------------------------
// Requests arrive on the s_ stream (s_tuser is the request type), results
// leave on the m_ stream (m_tuser is the result kind). Registers are written
// on the cfg_ channel, which is always ready; write it only while idle.
// One request is processed at a time. A tick that emits a step note runs
// the expiry scan, which visits one entry per cycle, then ranks the held
// notes and takes the step index from a bit-serial remainder. In random
// mode a step also draws from the generator, and every 624th draw first
// regenerates the generator state through its single-write memory.
// After reset, and after each seed write, s_tready stays low while the
// generator state is seeded one word per cycle.
// Results sit in an output register; while the receiver stalls, the next
// request is still accepted and processed, then waits for the register.
// ---------------------------------------------------------------------------
module note_arpeggiator_core #(
  parameter int HELD_DEPTH = arp_pkg::HELD_DEPTH_DEF,
  parameter int TIME_BITS  = arp_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // note_number, note_velocity, note_duration, event_time, transport_running
  input  logic [arp_pkg::IN_W-1:0]    s_tdata,
  // req_type
  input  logic [arp_pkg::USER_W-1:0]  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // out_note, out_velocity, out_duration, out_time, next_tick_time, store_full
  output logic [arp_pkg::OUT_W-1:0]   m_tdata,
  // out_kind
  output logic [arp_pkg::USER_W-1:0]  m_tuser,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [arp_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [31:0]                 cfg_data
);
  import arp_pkg::*;

  arp_cmd_t  cmd;
  arp_stat_t stat;

  assign cfg_ready = 1'b1;

  arp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  arp_dp #(
    .DEPTH (HELD_DEPTH),
    .TB    (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

### src/arp_checker.sv
// ---------------------------------------------------------------------------
// Arpeggiator port checker
// Watches the top-level ports over time.
// ---------------------------------------------------------------------------
module arp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [arp_pkg::IN_W-1:0]    s_tdata,
  input logic [arp_pkg::USER_W-1:0]  s_tuser,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [arp_pkg::OUT_W-1:0]   m_tdata,
  input logic [arp_pkg::USER_W-1:0]  m_tuser,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [arp_pkg::CIDX_W-1:0]  cfg_index,
  input logic [31:0]                 cfg_data
);
  import arp_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Seeding after reset keeps the input closed.
  a_reset_seed: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input open during reset seeding");

  // A seed write closes the input while the generator is reseeded.
  a_seed_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == CFG_SEED |=> !s_tready)
    else $error("input open after seed write");

  // A step note never carries the store-full flag.
  a_step_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_STEP |-> !m_tdata[110])
    else $error("step note flagged as dropped");

endmodule

bind note_arpeggiator_core arp_checker u_arp_checker (.*);

### test/arp_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Arpeggiator result checker
// Watches the request, result and register channels of the arpeggiator
// core. It keeps its own copy of the held-note store and the generator, and
// compares each result with the oldest predicted one, field by field.
// ---------------------------------------------------------------------------
module arp_scoreboard
  import arp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [IN_W-1:0]     s_tdata,
  input  logic [USER_W-1:0]   s_tuser,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [OUT_W-1:0]    m_tdata,
  input  logic [USER_W-1:0]   m_tuser,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  errors,
  output int                  pending
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [31:0] dur;
    logic [31:0] tim;
    logic [31:0] nxt;
    logic        full;
  } arp_event_t;

  arp_event_t expected_events[$];

  // Register copies.
  logic [1:0]  mode;
  logic [1:0]  span;
  logic [13:0] period;
  logic [13:0] gate;
  logic [6:0]  fixvel;
  logic        pass;

  // Held-note store and step state.
  logic [6:0]  pitch[HELD_DEPTH_DEF];
  logic [6:0]  level[HELD_DEPTH_DEF];
  logic [31:0] rel_time[HELD_DEPTH_DEF];
  logic        timed[HELD_DEPTH_DEF];
  int          held;
  logic [31:0] step_pos;
  logic [31:0] mt[MT_N];
  int          mt_idx;
  int          reported = 0;

  function automatic void mt_load(logic [31:0] s);
    mt[0] = s;
    for (int i = 1; i < MT_N; i++) begin
      mt[i] = MT_MULT * (mt[i-1] ^ (mt[i-1] >> 30)) + i;
    end
    mt_idx = MT_N;
  endfunction

  function automatic logic [31:0] mt_draw();
    logic [31:0] x;
    logic [31:0] v;
    logic [31:0] y;
    // Regenerate the whole state once every word has been used.
    if (mt_idx >= MT_N) begin
      for (int k = 0; k < MT_N; k++) begin
        x = (mt[k] & 32'h8000_0000) | (mt[(k + 1) % MT_N] & 32'h7fff_ffff);
        v = mt[(k + MT_M) % MT_N] ^ (x >> 1);
        if (x[0]) v = v ^ MT_MATRIX;
        mt[k] = v;
      end
      mt_idx = 0;
    end
    y = mt[mt_idx];
    mt_idx++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & MT_TMASKB);
    y = y ^ ((y << 15) & MT_TMASKC);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic void drop_entry(int k);
    for (int i = k; i + 1 < held; i++) begin
      pitch[i]    = pitch[i+1];
      level[i]    = level[i+1];
      rel_time[i] = rel_time[i+1];
      timed[i]    = timed[i+1];
    end
    held--;
  endfunction

  function automatic void drop_note(logic [6:0] nn);
    for (int i = 0; i < held; i++) begin
      if (pitch[i] == nn) begin
        drop_entry(i);
        return;
      end
    end
  endfunction

  function automatic arp_event_t make_event(logic [1:0] kind, logic [6:0] note,
      logic [6:0] vel, logic [31:0] dur, logic [31:0] tim, logic [31:0] nxt,
      logic full);
    arp_event_t e;
    e.kind = kind; e.note = note; e.vel = vel; e.dur = dur;
    e.tim = tim; e.nxt = nxt; e.full = full;
    return e;
  endfunction

  // Append one predicted result to the end of the expected list.
  function automatic void queue_expected(arp_event_t e);
    expected_events = {expected_events, e};
  endfunction

  // Work out the result, if any, of one request and update the store.
  function automatic void predict_arp_step(logic [1:0] req, logic [6:0] nn,
      logic [6:0] vv, logic [31:0] dur, logic [31:0] now, logic run);
    logic [31:0] nxt;
    int          sp[3*HELD_DEPTH_DEF];
    int          sv[3*HELD_DEPTH_DEF];
    int          len;
    int          j;
    int          p;
    int          v;
    int          cyc;
    int          k;
    logic [31:0] pick;
    logic [6:0]  ovel;
    case (req)
      REQ_NOTE_ON: begin
        drop_note(nn);
        if (held >= HELD_DEPTH_DEF) begin
          if (pass) queue_expected(make_event(KIND_FWD_ON, nn, vv, dur, now, 0, 1));
          else queue_expected(make_event(KIND_IDLE, 0, 0, 0, 0, 0, 1));
        end else begin
          pitch[held]    = nn;
          level[held]    = vv;
          timed[held]    = (dur != 0);
          rel_time[held] = (dur != 0) ? now + dur : 32'd0;
          held++;
          if (pass) queue_expected(make_event(KIND_FWD_ON, nn, vv, dur, now, 0, 0));
        end
      end
      REQ_NOTE_OFF: begin
        drop_note(nn);
        if (pass) queue_expected(make_event(KIND_FWD_OFF, nn, vv, dur, now, 0, 0));
      end
      REQ_TICK: begin
        nxt = now + period;
        // Expire timed notes that are due.
        for (int i = held - 1; i >= 0; i--) begin
          if (timed[i] && rel_time[i] <= now) drop_entry(i);
        end
        if (run && held > 0) begin
          // Insertion sort by pitch, then stack the octaves above.
          for (int i = 0; i < held; i++) begin
            p = pitch[i];
            v = level[i];
            j = i;
            while (j > 0 && sp[j-1] > p) begin
              sp[j] = sp[j-1];
              sv[j] = sv[j-1];
              j--;
            end
            sp[j] = p;
            sv[j] = v;
          end
          len = held;
          for (int o = 1; o < span; o++) begin
            for (int i = 0; i < held; i++) begin
              p = sp[i] + 12 * o;
              if (p <= 127) begin
                sp[len] = p;
                sv[len] = sv[i];
                len++;
              end
            end
          end
          case (mode)
            MODE_DOWN: pick = len - 1 - (step_pos % len);
            MODE_UPDOWN: begin
              if (len == 1) begin
                pick = 0;
              end else begin
                cyc = 2 * len - 2;
                k = step_pos % cyc;
                pick = (k < len) ? k : cyc - k;
              end
            end
            MODE_RANDOM: pick = mt_draw() % len;
            default: pick = step_pos % len;
          endcase
          ovel = (fixvel != 0) ? fixvel : 7'(sv[pick]);
          queue_expected(make_event(KIND_STEP, 7'(sp[pick]), ovel,
                                    {18'd0, gate}, now, nxt, 0));
          step_pos++;
        end else begin
          queue_expected(make_event(KIND_IDLE, 0, 0, 0, now, nxt, 0));
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    arp_event_t got;
    arp_event_t want;
    if (rst) begin
      mode = MODE_RST; span = SPAN_RST; period = PERIOD_RST; gate = GATE_RST;
      fixvel = 0; pass = 0;
      held = 0; step_pos = 0;
      mt_load(SEED_RST);
      expected_events.delete();
    end else begin
      // Register writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE:   mode = cfg_data[1:0];
          CFG_SPAN:   span = cfg_data[1:0];
          CFG_PERIOD: period = cfg_data[13:0];
          CFG_GATE:   gate = cfg_data[13:0];
          CFG_FIXVEL: fixvel = cfg_data[6:0];
          CFG_PASS:   pass = cfg_data[0];
          CFG_SEED:   mt_load(cfg_data);
          default: ;
        endcase
      end
      // Result transactions.
      if (m_tvalid && m_tready) begin
        got = make_event(m_tuser, m_tdata[6:0], m_tdata[13:7], m_tdata[45:14],
                         m_tdata[77:46], m_tdata[109:78], m_tdata[110]);
        if (expected_events.size() == 0) begin
          errors++;
          if (reported < 10) begin
            reported++;
            $display("ERROR: unexpected result kind %0d note %0d at %0t",
                     got.kind, got.note, $realtime);
          end
        end else begin
          want = expected_events.pop_front();
          if (got.kind != want.kind || got.note != want.note || got.vel != want.vel ||
              got.dur != want.dur || got.tim != want.tim || got.nxt != want.nxt ||
              got.full != want.full) begin
            errors++;
            if (reported < 10) begin
              reported++;
              $display("ERROR: expected kind %0d note %0d vel %0d dur %0h time %0h next %0h full %0b",
                       want.kind, want.note, want.vel, want.dur, want.tim, want.nxt, want.full);
              $display("       actual   kind %0d note %0d vel %0d dur %0h time %0h next %0h full %0b",
                       got.kind, got.note, got.vel, got.dur, got.tim, got.nxt, got.full);
            end
          end
        end
      end
      // Request transactions.
      if (s_tvalid && s_tready) begin
        predict_arp_step(s_tuser, s_tdata[6:0], s_tdata[13:7], s_tdata[45:14],
                         s_tdata[77:46], s_tdata[78]);
      end
    end
    pending = expected_events.size();
  end

endmodule

### test/note_arpeggiator_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Arpeggiator core testbench
// Drives note events and ticks through several register settings, with
// random gaps and receiver stalls, and lets the checker compare results.
// ---------------------------------------------------------------------------
module note_arpeggiator_core_test;
  import arp_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int PHASES     = 8;
  localparam int PHASE_REQS = 240;

  logic               clk = 0;
  logic               rst = 1;
  logic               s_tvalid = 0;
  logic               s_tready;
  logic [IN_W-1:0]    s_tdata = '0;
  logic [USER_W-1:0]  s_tuser = '0;
  logic               m_tvalid;
  logic               m_tready = 0;
  logic [OUT_W-1:0]   m_tdata;
  logic [USER_W-1:0]  m_tuser;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  int          errors;
  int          pending;
  int          sent = 0;
  int          results_seen = 0;
  int          idle_cycles = 0;
  int          settings = 0;
  logic        calm = 0;
  logic [31:0] now_t = 0;

  note_arpeggiator_core i_dut (.*);

  arp_scoreboard i_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Stop the run if no transaction happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stalls, with two long hold-offs so the core backs up.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
      results_seen++;
      if (results_seen == 60 || results_seen == 1200) begin
        m_tready <= 0;
        repeat (3000) @(posedge clk);
      end
    end
  end

  task automatic send_req(input logic [1:0] req, input logic [6:0] nn, input logic [6:0] vv,
                          input logic [31:0] dur, input logic [31:0] t, input logic run);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= req;
    s_tdata  <= {1'b0, run, t, dur, vv, nn};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // Let every outstanding result drain, then give no-result work time to end.
  task automatic wait_quiet();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // One random request, mostly well-formed traffic around a moving clock.
  task automatic send_random();
    int          r;
    logic [6:0]  nn;
    logic [31:0] dur;
    r  = $urandom_range(0, 99);
    nn = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(40, 75));
    if (r < 5) begin
      send_req(2'($urandom_range(0, 3)), 7'($urandom), 7'($urandom), $urandom, $urandom,
               1'($urandom));
    end else if (r < 45) begin
      now_t = now_t + $urandom_range(0, 400);
      send_req(REQ_TICK, 7'($urandom), 7'($urandom), $urandom, now_t,
               $urandom_range(0, 9) != 0);
    end else if (r < 80) begin
      case ($urandom_range(0, 3)) inside
        0, 1: dur = 0;
        2: dur = $urandom_range(1, 2000);
        default: dur = $urandom;
      endcase
      send_req(REQ_NOTE_ON, nn, 7'($urandom), dur, now_t, 1'($urandom));
    end else begin
      send_req(REQ_NOTE_OFF, nn, 7'($urandom), $urandom, now_t, 1'($urandom));
    end
  endtask

  initial begin
    logic [31:0] val;
    repeat (10) @(posedge clk);
    rst <= 0;

    // Directed: empty store, extremes, due test at its boundary.
    send_req(REQ_TICK, 0, 0, 0, 32'd10, 1);
    send_req(REQ_TICK, 7'd127, 7'd127, 32'hffff_ffff, 32'd20, 0);
    send_req(REQ_NOTE_ON, 7'd0, 7'd0, 32'd0, 32'd30, 0);
    send_req(REQ_NOTE_ON, 7'd127, 7'd127, 32'hffff_ffff, 32'hffff_ffff, 1);
    send_req(REQ_NOTE_ON, 7'd60, 7'd64, 32'd5, 32'd100, 0);
    send_req(REQ_TICK, 0, 0, 0, 32'd104, 1);
    send_req(REQ_TICK, 0, 0, 0, 32'd105, 1);
    send_req(REQ_TICK, 0, 0, 0, 32'd106, 0);
    send_req(REQ_NOTE_OFF, 7'd33, 7'd5, 32'd7, 32'd107, 0);
    send_req(2'd3, 7'd12, 7'd12, 32'd12, 32'd108, 1);
    send_req(REQ_TICK, 0, 0, 0, 32'hffff_ffff, 1);
    // Fill the store past its depth, then replace a held note while full.
    for (int i = 0; i < 18; i++) send_req(REQ_NOTE_ON, 7'(100 + i), 7'(i + 1), 0, 32'd200, 0);
    send_req(REQ_NOTE_ON, 7'd100, 7'd99, 0, 32'd201, 0);
    send_req(REQ_TICK, 0, 0, 0, 32'd210, 1);
    wait_quiet();
    write_reg(CFG_PASS, 1);
    send_req(REQ_NOTE_ON, 7'd50, 7'd50, 32'd9, 32'd300, 0);
    send_req(REQ_NOTE_OFF, 7'd101, 7'd3, 32'd4, 32'd301, 0);
    for (int i = 0; i < 18; i++) send_req(REQ_NOTE_OFF, 7'(100 + i), 0, 0, 32'd302, 0);
    send_req(REQ_NOTE_OFF, 7'd0, 0, 0, 32'd303, 0);

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_quiet();
      write_reg(CFG_MODE, ph % 4);
      write_reg(CFG_SPAN, (ph == 7) ? 0 : 1 + ph % 3);
      val = (ph == 0) ? 20 : (ph == 1) ? 10000 : (ph == 2) ? 16383 : $urandom_range(20, 10000);
      write_reg(CFG_PERIOD, val);
      val = (ph == 0) ? 10000 : (ph == 1) ? 10 : (ph == 2) ? 0 : $urandom_range(10, 10000);
      write_reg(CFG_GATE, val);
      val = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 127 : $urandom_range(1, 126);
      write_reg(CFG_FIXVEL, val);
      write_reg(CFG_PASS, (ph / 2) % 2);
      if (ph == 3) write_reg(CFG_SEED, 32'hffff_ffff);
      if (ph == 6) write_reg(CFG_SEED, $urandom);
      if (ph == 7) write_reg(CFG_SEED, 32'd0);
      if (ph == 5) write_reg(3'd7, $urandom);
      settings++;
      calm  = (ph == 2);
      now_t = (ph == 4) ? 32'hffff_f000 : $urandom;
      for (int n = 0; n < PHASE_REQS; n++) send_random();
    end

    wait_quiet();
    repeat (200) @(posedge clk);
    $display("Sent %0d requests over %0d register settings; %0d results checked.",
             sent, settings, results_seen);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
